// ----- rtl/gpa_pkg.sv -----
`timescale 1ns / 1ps

package gpa_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int HALF_SPAN_DEF = 100;
    localparam int FIFO_DEPTH    = 4;

    // s and the log2 mantissa are Q0.32 / Q1.31
    localparam int SQ_W = 32;
    // -log2(s) and -ln(s) in Q32 with up to six integer bits
    localparam int L2_W = 38;

    // ln 2 rounded to Q32
    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    typedef struct packed {
        logic acc;
        logic neg;
    } t_ctl;

    // bits needed for |a - H| over an 8-bit uniform input
    function automatic int ada_w(input int h);
        int m;
        m = (h > 255 - h) ? h : 255 - h;
        return $clog2(m + 1);
    endfunction

endpackage

// ----- rtl/gpa_front.sv -----
`timescale 1ns / 1ps

module gpa_front #(
    parameter int UNIFORM_HALF_SPAN = gpa_pkg::HALF_SPAN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_spectrum_power,
    input  logic [7:0]           i_uniform_a,
    input  logic [7:0]           i_uniform_b,
    input  logic                 i_full,
    output logic                 o_valid,
    output logic [31:0]          o_power,
    output logic [2*gpa_pkg::ada_w(UNIFORM_HALF_SPAN)-1:0] o_ada2,
    output logic [2*gpa_pkg::ada_w(UNIFORM_HALF_SPAN):0]   o_n,
    output gpa_pkg::t_ctl        o_ctl
);

    localparam int AW  = gpa_pkg::ada_w(UNIFORM_HALF_SPAN);
    localparam int A2W = 2 * AW;
    localparam int NW  = A2W + 1;
    localparam logic [NW-1:0] D_N = NW'(UNIFORM_HALF_SPAN * UNIFORM_HALF_SPAN);

    logic              r_valid;
    logic [31:0]       r_power;
    logic [A2W-1:0]    r_ada2;
    logic [NW-1:0]     r_n;
    gpa_pkg::t_ctl     r_ctl;

    logic signed [AW:0] w_da, w_db;
    logic [AW-1:0]      w_ada, w_adb;
    logic [A2W-1:0]     n_ada2, w_adb2;
    logic [NW-1:0]      n_n;
    gpa_pkg::t_ctl      n_ctl;

    assign o_stall = r_valid && i_full;

    always_comb begin
        w_da   = $signed((AW+1)'(i_uniform_a)) - $signed((AW+1)'(UNIFORM_HALF_SPAN));
        w_db   = $signed((AW+1)'(i_uniform_b)) - $signed((AW+1)'(UNIFORM_HALF_SPAN));
        w_ada  = w_da[AW] ? AW'(-w_da) : AW'(w_da);
        w_adb  = w_db[AW] ? AW'(-w_db) : AW'(w_db);
        n_ada2 = A2W'(w_ada) * A2W'(w_ada);
        w_adb2 = A2W'(w_adb) * A2W'(w_adb);
        n_n    = NW'(n_ada2) + NW'(w_adb2);
        n_ctl.acc = (n_n != '0) && (n_n < D_N);
        n_ctl.neg = w_da[AW];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_power <= i_spectrum_power;
            r_ada2  <= n_ada2;
            r_n     <= n_n;
            r_ctl   <= n_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_power = r_power;
    assign o_ada2  = r_ada2;
    assign o_n     = r_n;
    assign o_ctl   = r_ctl;

endmodule

// ----- rtl/gpa_fifo.sv -----
`timescale 1ns / 1ps

module gpa_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gpa_pkg::FIFO_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- rtl/gpa_div.sv -----
`timescale 1ns / 1ps

module gpa_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 8,
    parameter int Q_W   = 8,
    parameter int PAY_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [Q_W-1:0]   o_quo,
    output logic [PAY_W-1:0] o_pay
);

    localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic             w_valid [Q_W+1];
    logic [NUM_W-1:0] w_rem   [Q_W+1];
    logic [DEN_W-1:0] w_den   [Q_W+1];
    logic [Q_W-1:0]   w_quo   [Q_W+1];
    logic [PAY_W-1:0] w_pay   [Q_W+1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_num;
    assign w_den[0]   = i_den;
    assign w_quo[0]   = '0;
    assign w_pay[0]   = i_pay;

    // one quotient bit a stage, most significant first
    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        localparam int K = Q_W - 1 - g;
        logic [CW-1:0]    w_sub;
        logic             w_ge;
        logic [NUM_W-1:0] n_rem;
        logic [Q_W-1:0]   n_quo;
        logic             r_valid;
        logic [NUM_W-1:0] r_rem;
        logic [DEN_W-1:0] r_den;
        logic [Q_W-1:0]   r_quo;
        logic [PAY_W-1:0] r_pay;

        always_comb begin
            w_sub = CW'(w_den[g]) << K;
            w_ge  = CW'(w_rem[g]) >= w_sub;
            n_rem = w_ge ? NUM_W'(CW'(w_rem[g]) - w_sub) : w_rem[g];
            n_quo = w_ge ? (w_quo[g] | (Q_W'(1) << K)) : w_quo[g];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem <= n_rem;
                r_den <= w_den[g];
                r_quo <= n_quo;
                r_pay <= w_pay[g];
            end
        end

        assign w_valid[g+1] = r_valid;
        assign w_rem[g+1]   = r_rem;
        assign w_den[g+1]   = r_den;
        assign w_quo[g+1]   = r_quo;
        assign w_pay[g+1]   = r_pay;
    end

    assign o_valid = w_valid[Q_W];
    assign o_quo   = w_quo[Q_W];
    assign o_pay   = w_pay[Q_W];

endmodule

// ----- rtl/gpa_log2.sv -----
`timescale 1ns / 1ps

module gpa_log2 #(
    parameter int PAY_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic [gpa_pkg::SQ_W-1:0] i_sq,
    input  logic [PAY_W-1:0]         i_pay,
    output logic                     o_valid,
    output logic [4:0]               o_zeros,
    output logic [gpa_pkg::SQ_W-1:0] o_frac,
    output logic [PAY_W-1:0]         o_pay
);

    localparam int SW = gpa_pkg::SQ_W;

    logic          w_valid [SW+1];
    logic [4:0]    w_z     [SW+1];
    logic [SW-1:0] w_m     [SW+1];
    logic [SW-1:0] w_frac  [SW+1];
    logic [PAY_W-1:0] w_pay [SW+1];

    logic [4:0]    n_z;
    logic [SW-1:0] n_m;
    logic          r_valid;
    logic [4:0]    r_z;
    logic [SW-1:0] r_m;
    logic [PAY_W-1:0] r_pay;

    // normalise the mantissa to bit 31
    always_comb begin
        n_z = '0;
        for (int i = 0; i < SW; i++) begin
            if (i_sq[i]) begin
                n_z = 5'(SW - 1 - i);
            end
        end
        n_m = i_sq << n_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_z   <= n_z;
            r_m   <= n_m;
            r_pay <= i_pay;
        end
    end

    assign w_valid[0] = r_valid;
    assign w_z[0]     = r_z;
    assign w_m[0]     = r_m;
    assign w_frac[0]  = '0;
    assign w_pay[0]   = r_pay;

    // one fraction bit a stage by squaring
    for (genvar g = 0; g < SW; g++) begin : g_sqr
        logic [2*SW-1:0] w_prod;
        logic [SW:0]     w_t;
        logic [SW-1:0]   n_mm;
        logic [SW-1:0]   n_frac;
        logic            rs_valid;
        logic [4:0]      rs_z;
        logic [SW-1:0]   rs_m;
        logic [SW-1:0]   rs_frac;
        logic [PAY_W-1:0] rs_pay;

        always_comb begin
            w_prod = (2*SW)'(w_m[g]) * (2*SW)'(w_m[g]);
            w_t    = w_prod[2*SW-1:SW-1];
            n_mm   = w_t[SW] ? w_t[SW:1] : w_t[SW-1:0];
            n_frac = {w_frac[g][SW-2:0], w_t[SW]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                rs_valid <= 1'b0;
            end else if (i_en) begin
                rs_valid <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                rs_z    <= w_z[g];
                rs_m    <= n_mm;
                rs_frac <= n_frac;
                rs_pay  <= w_pay[g];
            end
        end

        assign w_valid[g+1] = rs_valid;
        assign w_z[g+1]     = rs_z;
        assign w_m[g+1]     = rs_m;
        assign w_frac[g+1]  = rs_frac;
        assign w_pay[g+1]   = rs_pay;
    end

    assign o_valid = w_valid[SW];
    assign o_zeros = w_z[SW];
    assign o_frac  = w_frac[SW];
    assign o_pay   = w_pay[SW];

endmodule

// ----- rtl/gpa_sqrt.sv -----
`timescale 1ns / 1ps

module gpa_sqrt #(
    parameter int PAY_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [63:0]      i_x,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_valid,
    output logic [31:0]      o_root,
    output logic [PAY_W-1:0] o_pay
);

    logic             w_valid [33];
    logic [63:0]      w_x     [33];
    logic [33:0]      w_rem   [33];
    logic [31:0]      w_root  [33];
    logic [PAY_W-1:0] w_pay   [33];

    assign w_valid[0] = i_valid;
    assign w_x[0]     = i_x;
    assign w_rem[0]   = '0;
    assign w_root[0]  = '0;
    assign w_pay[0]   = i_pay;

    // one root bit a stage, two radicand bits brought down each time
    for (genvar g = 0; g < 32; g++) begin : g_digit
        localparam int K = 31 - g;
        logic [35:0] w_t;
        logic [35:0] w_try;
        logic        w_ge;
        logic [33:0] n_rem;
        logic [31:0] n_root;
        logic             r_valid;
        logic [63:0]      r_x;
        logic [33:0]      r_rem;
        logic [31:0]      r_root;
        logic [PAY_W-1:0] r_pay;

        always_comb begin
            w_t    = {w_rem[g], w_x[g][2*K+1 -: 2]};
            w_try  = 36'({w_root[g], 2'b01});
            w_ge   = w_t >= w_try;
            n_rem  = w_ge ? 34'(w_t - w_try) : w_t[33:0];
            n_root = {w_root[g][30:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid <= 1'b0;
            end else if (i_en) begin
                r_valid <= w_valid[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x    <= w_x[g];
                r_rem  <= n_rem;
                r_root <= n_root;
                r_pay  <= w_pay[g];
            end
        end

        assign w_valid[g+1] = r_valid;
        assign w_x[g+1]     = r_x;
        assign w_rem[g+1]   = r_rem;
        assign w_root[g+1]  = r_root;
        assign w_pay[g+1]   = r_pay;
    end

    assign o_valid = w_valid[32];
    assign o_root  = w_root[32];
    assign o_pay   = w_pay[32];

endmodule

// ----- rtl/polar_gaussian_spectrum_amplitude_unit.sv -----
`timescale 1ns / 1ps

// Gaussian spectrum amplitude by the polar rejection method. Each input word
// carries a spectrum power P (unsigned Q8.24 by default) and two uniform
// integers a and b; the block returns one result word per input word, in
// order: sqrt(P/2) * u * sqrt(-ln(s)/s) in signed Q8.24, saturated, with
// accepted set, or a zero amplitude with accepted clear when the pair falls
// on or outside the unit circle, or on its centre (retry the same P with a new
// pair). One word is taken every clock unless the input stage holds a word
// that the full queue cannot take. Most of the pipe depth is set by the three
// bit-serial pipelines: the 32-stage squaring log2, a FRAC_BITS+6 stage
// divider for u^2*(-ln s)/s and the 32-stage square root; s = n/H^2 itself
// comes from a two-stage reciprocal multiply. A four-word queue sits between
// the input stage and the arithmetic pipe; the pipe freezes as a whole only
// while its output register holds a word that the receiver stalls.
module polar_gaussian_spectrum_amplitude_unit #(
    parameter int FRAC_BITS         = gpa_pkg::FRAC_BITS_DEF,
    parameter int UNIFORM_HALF_SPAN = gpa_pkg::HALF_SPAN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [31:0]        i_spectrum_power,
    input  logic [7:0]         i_uniform_a,
    input  logic [7:0]         i_uniform_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_amplitude,
    output logic               o_accepted
);

    localparam int AW   = gpa_pkg::ada_w(UNIFORM_HALF_SPAN);
    localparam int A2W  = 2 * AW;
    localparam int NW   = A2W + 1;
    localparam int DV   = UNIFORM_HALF_SPAN * UNIFORM_HALF_SPAN;
    localparam int DVW  = $clog2(DV + 1);
    localparam int LW   = gpa_pkg::L2_W;
    localparam int SW   = gpa_pkg::SQ_W;
    localparam int SH   = 32 - FRAC_BITS;
    localparam int GW   = FRAC_BITS + 6;
    localparam int LOW  = GW / 2;
    localparam int HIW  = GW - LOW;
    localparam int PW   = 32 + GW;
    localparam int XW   = (PW > 64) ? PW : 65;
    localparam int NUMW = A2W + LW;
    localparam int DENW = NW + SH;
    localparam int PAY1 = 32 + A2W + NW + 2;
    localparam int PAY2 = 32 + 2;
    localparam int PAY3 = 1 + 2;

    // floor(n * 2^32 / H^2) == floor(n * REC / 2^(2*DVW)) with
    // REC = ceil(2^RS / H^2); exact for every n below H^2
    localparam int RS   = 32 + 2 * DVW;
    localparam int MW   = RS - DVW + 2;
    localparam int RLO  = MW / 2;
    localparam int RHI  = MW - RLO;
    localparam int PRW  = NW + MW;
    localparam logic [RS:0]   REC_POW  = (RS+1)'(1) << RS;
    localparam logic [RS:0]   REC_FULL = (REC_POW + (RS+1)'(DV - 1)) / (RS+1)'(DV);
    localparam logic [MW-1:0] REC      = MW'(REC_FULL);

    // ---------------------------------------------------------------------
    // Front: take the word, classify the pair, queue it
    // ---------------------------------------------------------------------
    logic            w_f_valid;
    logic [31:0]     w_f_power;
    logic [A2W-1:0]  w_f_ada2;
    logic [NW-1:0]   w_f_n;
    gpa_pkg::t_ctl   w_f_ctl;
    logic            w_q_full, w_q_empty, w_q_push, w_q_pop;
    logic [PAY1-1:0] w_q_data;
    logic            w_adv;

    gpa_front #(
        .UNIFORM_HALF_SPAN(UNIFORM_HALF_SPAN)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_in_valid),
        .o_stall         (o_in_stall),
        .i_spectrum_power(i_spectrum_power),
        .i_uniform_a     (i_uniform_a),
        .i_uniform_b     (i_uniform_b),
        .i_full          (w_q_full),
        .o_valid         (w_f_valid),
        .o_power         (w_f_power),
        .o_ada2          (w_f_ada2),
        .o_n             (w_f_n),
        .o_ctl           (w_f_ctl)
    );

    assign w_q_push = w_f_valid && !w_q_full;
    // the back end moves whenever its output register is free or drained
    assign w_adv    = !o_out_valid || !i_out_stall;
    assign w_q_pop  = w_adv && !w_q_empty;

    gpa_fifo #(
        .WIDTH(PAY1),
        .DEPTH(gpa_pkg::FIFO_DEPTH)
    ) u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_q_push),
        .i_data ({w_f_power, w_f_ada2, w_f_n, w_f_ctl}),
        .o_full (w_q_full),
        .i_pop  (w_q_pop),
        .o_empty(w_q_empty),
        .o_data (w_q_data)
    );

    // ---------------------------------------------------------------------
    // Back: s = n / H^2 in Q0.32, two partial products then sum and shift
    // ---------------------------------------------------------------------
    logic [NW-1:0]     w_q_n;
    logic              r_sa_valid;
    logic [NW+RLO-1:0] r_sa_lo;
    logic [NW+RHI-1:0] r_sa_hi;
    logic [PAY1-1:0]   r_sa_pay;
    logic [PRW-1:0]    w_sa_sum;
    logic              r_sb_valid;
    logic [SW-1:0]     r_sq;
    logic [PAY1-1:0]   r_sb_pay;

    assign w_q_n = w_q_data[NW+1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sa_valid <= 1'b0;
        end else if (w_adv) begin
            r_sa_valid <= !w_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sa_lo  <= (NW+RLO)'(w_q_n) * (NW+RLO)'(REC[RLO-1:0]);
            r_sa_hi  <= (NW+RHI)'(w_q_n) * (NW+RHI)'(REC[MW-1:RLO]);
            r_sa_pay <= w_q_data;
        end
    end

    assign w_sa_sum = (PRW'(r_sa_hi) << RLO) + PRW'(r_sa_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sb_valid <= 1'b0;
        end else if (w_adv) begin
            r_sb_valid <= r_sa_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq     <= w_sa_sum[RS-1:RS-32];
            r_sb_pay <= r_sa_pay;
        end
    end

    // -log2(s): normalise, then one bit a stage
    logic            w_lg_valid;
    logic [4:0]      w_lg_z;
    logic [SW-1:0]   w_lg_frac;
    logic [PAY1-1:0] w_lg_pay;

    gpa_log2 #(
        .PAY_W(PAY1)
    ) u_log2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_valid(r_sb_valid),
        .i_sq   (r_sq),
        .i_pay  (r_sb_pay),
        .o_valid(w_lg_valid),
        .o_zeros(w_lg_z),
        .o_frac (w_lg_frac),
        .o_pay  (w_lg_pay)
    );

    // assemble L2 = (1+z)*2^32 - fraction
    logic            r_l_valid;
    logic [LW-1:0]   r_l2;
    logic [PAY1-1:0] r_l_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_valid <= 1'b0;
        end else if (w_adv) begin
            r_l_valid <= w_lg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_l2    <= (LW'(6'(w_lg_z) + 6'd1) << 32) - LW'(w_lg_frac);
            r_l_pay <= w_lg_pay;
        end
    end

    // convert to natural log, -ln(s) in Q32
    logic [63:0]     w_lo_prod;
    logic [LW-1:0]   n_lnq;
    logic            r_m_valid;
    logic [LW-1:0]   r_lnq;
    logic [PAY1-1:0] r_m_pay;

    always_comb begin
        w_lo_prod = 64'(r_l2[31:0]) * 64'(gpa_pkg::LN2_Q32);
        n_lnq     = LW'(r_l2[LW-1:32]) * LW'(gpa_pkg::LN2_Q32) + LW'(w_lo_prod[63:32]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv) begin
            r_m_valid <= r_l_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_lnq   <= n_lnq;
            r_m_pay <= r_l_pay;
        end
    end

    // numerator da^2 * lnq and denominator n scaled to the output format
    logic [31:0]     w_m_power;
    logic [A2W-1:0]  w_m_ada2;
    logic [NW-1:0]   w_m_n;
    gpa_pkg::t_ctl   w_m_ctl;
    logic            r_n_valid;
    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [PAY2-1:0] r_n_pay;

    assign {w_m_power, w_m_ada2, w_m_n, w_m_ctl} = r_m_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_valid <= 1'b0;
        end else if (w_adv) begin
            r_n_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_num   <= NUMW'(w_m_ada2) * NUMW'(r_lnq);
            r_den   <= DENW'(w_m_n) << SH;
            r_n_pay <= {w_m_power, w_m_ctl};
        end
    end

    // g2 = u^2 * (-ln s) / s in Q(FRAC_BITS)
    logic            w_d2_valid;
    logic [GW-1:0]   w_g2;
    logic [PAY2-1:0] w_d2_pay;

    gpa_div #(
        .NUM_W(NUMW),
        .DEN_W(DENW),
        .Q_W  (GW),
        .PAY_W(PAY2)
    ) u_div_g (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_valid(r_n_valid),
        .i_num  (r_num),
        .i_den  (r_den),
        .i_pay  (r_n_pay),
        .o_valid(w_d2_valid),
        .o_quo  (w_g2),
        .o_pay  (w_d2_pay)
    );

    // P * g2 in two partial products, then sum, halve and flag overflow
    logic [31:0]       w_d2_power;
    gpa_pkg::t_ctl     w_d2_ctl;
    logic              r_a_valid;
    logic [32+LOW-1:0] r_pl;
    logic [32+HIW-1:0] r_ph;
    gpa_pkg::t_ctl     r_a_ctl;

    assign {w_d2_power, w_d2_ctl} = w_d2_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= w_d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pl    <= (32+LOW)'(w_d2_power) * (32+LOW)'(w_g2[LOW-1:0]);
            r_ph    <= (32+HIW)'(w_d2_power) * (32+HIW)'(w_g2[GW-1:LOW]);
            r_a_ctl <= w_d2_ctl;
        end
    end

    logic [XW-1:0] w_full;
    logic          r_b_valid;
    logic [63:0]   r_b_x;
    logic          r_b_ovf;
    gpa_pkg::t_ctl r_b_ctl;

    assign w_full = (XW'(r_ph) << LOW) + XW'(r_pl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b_x   <= w_full[64:1];
            r_b_ovf <= |w_full[XW-1:64];
            r_b_ctl <= r_a_ctl;
        end
    end

    // magnitude = floor(sqrt(x))
    logic            w_sr_valid;
    logic [31:0]     w_root;
    logic [PAY3-1:0] w_sr_pay;
    logic            w_sr_ovf;
    gpa_pkg::t_ctl   w_sr_ctl;

    gpa_sqrt #(
        .PAY_W(PAY3)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_adv),
        .i_valid(r_b_valid),
        .i_x    (r_b_x),
        .i_pay  ({r_b_ovf, r_b_ctl}),
        .o_valid(w_sr_valid),
        .o_root (w_root),
        .o_pay  (w_sr_pay)
    );

    assign {w_sr_ovf, w_sr_ctl} = w_sr_pay;

    // ---------------------------------------------------------------------
    // Sign, saturate, hold in the output register
    // ---------------------------------------------------------------------
    logic [32:0] w_mag, w_mneg;
    logic [31:0] n_amp;
    logic        r_out_valid;
    logic [31:0] r_amp;
    logic        r_acc;

    always_comb begin
        w_mag  = w_sr_ovf ? 33'h1_0000_0000 : {1'b0, w_root};
        w_mneg = (w_mag > 33'h0_8000_0000) ? 33'h0_8000_0000 : w_mag;
        if (!w_sr_ctl.acc) begin
            n_amp = '0;
        end else if (!w_sr_ctl.neg) begin
            n_amp = (w_mag > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w_mag[31:0];
        end else begin
            n_amp = 32'(33'd0 - w_mneg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_sr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_amp <= n_amp;
            r_acc <= w_sr_ctl.acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_amplitude = $signed(r_amp);
    assign o_accepted  = r_acc;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_accepted) |-> (o_amplitude == 32'sd0))
        else $error("rejected pair carries a non-zero amplitude");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> ($stable(r_b_x) && $stable(r_b_valid)))
        else $error("back end moved while its result was stalled");

    a_queue_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_q_full && w_f_valid && !w_q_push))
        else $error("input stalled while the queue had room");

endmodule

// ----- dv/gpa_checker.sv -----
`timescale 1ns / 1ps

module gpa_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [31:0]        i_spectrum_power,
    input  logic [7:0]         i_uniform_a,
    input  logic [7:0]         i_uniform_b,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [31:0] i_amplitude,
    input  logic               i_accepted,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_n_accepted,
    output int                 o_n_rejected
);

    localparam int FRAC = gpa_pkg::FRAC_BITS_DEF;
    localparam int HALF = gpa_pkg::HALF_SPAN_DEF;

    typedef struct packed {
        logic signed [31:0] amp;
        logic               acc;
    } t_amp_word;

    t_amp_word amp_expected_q[$];

    function automatic logic [63:0] int_sqrt64(input logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // -log2(sq / 2^32) in Q32 by repeated squaring
    function automatic logic [63:0] minus_log2_q32(input logic [63:0] sq);
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] z;
        m = sq & 64'hFFFF_FFFF;
        frac = 0;
        z = 0;
        if (m == 0) return 0;
        while (m[31] == 1'b0) begin
            m = m << 1;
            z = z + 1;
        end
        for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m[32]) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return ((64'd1 + z) << 32) - frac;
    endfunction

    function automatic t_amp_word gauss_amplitude(input logic [31:0] p,
                                                  input logic [7:0] a,
                                                  input logic [7:0] b);
        int          da;
        int          db;
        logic [63:0] ada, adb, n, sq, l2, lnq, g2, mag;
        logic [127:0] prod;
        t_amp_word   w;
        da = int'(a) - HALF;
        db = int'(b) - HALF;
        ada = 64'(da < 0 ? -da : da);
        adb = 64'(db < 0 ? -db : db);
        n = ada * ada + adb * adb;
        w.amp = '0;
        w.acc = 1'b0;
        if (n == 0 || n >= 64'(HALF * HALF)) return w;
        sq = (n << 32) / 64'(HALF * HALF);
        l2 = minus_log2_q32(sq);
        lnq = (l2 >> 32) * 64'(gpa_pkg::LN2_Q32)
            + (((l2 & 64'hFFFF_FFFF) * 64'(gpa_pkg::LN2_Q32)) >> 32);
        g2 = (ada * ada * lnq) / (n << (32 - FRAC));
        prod = 128'(p) * 128'(g2);
        if (prod[127:64] != 0) mag = 64'd1 << 32;
        else mag = int_sqrt64(prod[63:0] >> 1);
        if (da >= 0) begin
            w.amp = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        end else begin
            if (mag > 64'h8000_0000) mag = 64'h8000_0000;
            w.amp = 32'(64'd0 - mag);
        end
        w.acc = 1'b1;
        return w;
    endfunction

    assign o_pending = amp_expected_q.size();

    always @(posedge i_clk) begin
        t_amp_word want;
        if (!i_rst_n) begin
            o_fail_count <= 0;
            o_n_accepted <= 0;
            o_n_rejected <= 0;
        end else begin
            if (i_in_valid && !i_in_stall)
                amp_expected_q.push_back(gauss_amplitude(i_spectrum_power,
                                                         i_uniform_a, i_uniform_b));
            if (i_out_valid && !i_out_stall) begin
                if (amp_expected_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: unexpected result amp=%h acc=%b",
                                 i_amplitude, i_accepted);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = amp_expected_q.pop_front();
                    if (want.amp !== i_amplitude || want.acc !== i_accepted) begin
                        if (o_fail_count < 10)
                            $display("ERROR: amp exp=%h got=%h, acc exp=%b got=%b",
                                     want.amp, i_amplitude, want.acc, i_accepted);
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (want.acc) o_n_accepted <= o_n_accepted + 1;
                    else o_n_rejected <= o_n_rejected + 1;
                end
            end
        end
    end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [31:0]        i_spectrum_power;
    logic [7:0]         i_uniform_a;
    logic [7:0]         i_uniform_b;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_amplitude;
    logic               o_accepted;

    int fail_count;
    int pending;
    int n_accepted;
    int n_rejected;
    int words_sent;

    // receiver-side state: one long hold-off, otherwise a shifting stall pattern
    int  hold_cycles;
    bit  hold_done;
    int  stall_mode;
    int  mode_left;

    polar_gaussian_spectrum_amplitude_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_spectrum_power (i_spectrum_power),
        .i_uniform_a      (i_uniform_a),
        .i_uniform_b      (i_uniform_b),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_amplitude      (o_amplitude),
        .o_accepted       (o_accepted)
    );

    gpa_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_spectrum_power (i_spectrum_power),
        .i_uniform_a      (i_uniform_a),
        .i_uniform_b      (i_uniform_b),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_amplitude      (o_amplitude),
        .i_accepted       (o_accepted),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_n_accepted     (n_accepted),
        .o_n_rejected     (n_rejected)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Receiver: hold off for a long stretch once, mid-run, so the queue and
    // the pipe fill and the input stalls; otherwise cycle through patterns.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_cycles <= 0;
            hold_done   <= 1'b0;
            stall_mode  <= 0;
            mode_left   <= 64;
        end else if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (!hold_done && words_sent >= 200) begin
            i_out_stall <= 1'b1;
            hold_cycles <= 400;
            hold_done   <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(16, 128);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // Offer one word and hold it until the block takes it. Stall is sampled
    // at the falling edge, where it is settled for the coming rising edge.
    task automatic offer_word(input logic [31:0] p, input logic [7:0] a,
                              input logic [7:0] b);
        bit taken;
        i_in_valid       <= 1'b1;
        i_spectrum_power <= p;
        i_uniform_a      <= a;
        i_uniform_b      <= b;
        forever begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
            if (taken) break;
        end
        words_sent++;
    endtask

    task automatic go_idle(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_power();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return $urandom_range(0, 65535);
            2: return $urandom_range(0, 32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int burst;
        int drain;
        logic [7:0] a;
        logic [7:0] b;
        i_rst_n          <= 1'b0;
        i_in_valid       <= 1'b0;
        i_spectrum_power <= '0;
        i_uniform_a      <= '0;
        i_uniform_b      <= '0;
        words_sent        = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: centre, circle edge, out-of-span values, da of zero,
        // smallest s, largest magnitudes in both signs, power extremes.
        offer_word(32'h0100_0000, 8'd100, 8'd100);
        offer_word(32'h0100_0000, 8'd0,   8'd100);
        offer_word(32'h0100_0000, 8'd200, 8'd100);
        offer_word(32'h0100_0000, 8'd100, 8'd0);
        offer_word(32'h0100_0000, 8'd100, 8'd200);
        offer_word(32'h0100_0000, 8'd255, 8'd255);
        offer_word(32'h0100_0000, 8'd201, 8'd100);
        offer_word(32'h0100_0000, 8'd1,   8'd100);
        offer_word(32'h0100_0000, 8'd199, 8'd100);
        offer_word(32'h0100_0000, 8'd100, 8'd1);
        offer_word(32'h0100_0000, 8'd100, 8'd101);
        offer_word(32'h0100_0000, 8'd101, 8'd100);
        offer_word(32'h0100_0000, 8'd99,  8'd100);
        offer_word(32'hFFFF_FFFF, 8'd101, 8'd100);
        offer_word(32'hFFFF_FFFF, 8'd99,  8'd100);
        offer_word(32'hFFFF_FFFF, 8'd170, 8'd130);
        offer_word(32'hFFFF_FFFF, 8'd30,  8'd70);
        offer_word(32'h0000_0000, 8'd150, 8'd150);
        offer_word(32'h0000_0001, 8'd150, 8'd50);
        offer_word(32'h8000_0000, 8'd129, 8'd171);
        offer_word(32'h0100_0000, 8'd171, 8'd100);
        go_idle(3);

        // Random: mostly in-span pairs, some full-byte noise; a burst either
        // runs straight into the next one or is followed by an idle pause
        while (words_sent < 470) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
                if ($urandom_range(0, 9) == 0) begin
                    a = $urandom_range(0, 255);
                    b = $urandom_range(0, 255);
                end else begin
                    a = $urandom_range(0, 200);
                    b = $urandom_range(0, 200);
                end
                offer_word(pick_power(), a, b);
            end
            if ($urandom_range(0, 3) != 0) go_idle($urandom_range(1, 12));
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        drain = 0;
        while (drain < 300) begin
            @(posedge i_clk);
            drain++;
        end

        $display("Sent %0d words: %0d accepted pairs, %0d rejected, with bursts,",
                 words_sent, n_accepted, n_rejected);
        $display("random output stalls and one long output hold-off.");
        if (fail_count == 0)
            $display("polar_gaussian_spectrum_amplitude_unit test passed");
        else
            $display("polar_gaussian_spectrum_amplitude_unit test failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("polar_gaussian_spectrum_amplitude_unit test failed");
        $finish;
    end

endmodule
